FILE: rtl/core/tte_pkg.sv
// ----------------------------------------------------------------------------
// tte_pkg: shared types and constants for the timer table engine
// Command and status codes, field widths and the queue entry between front and back.
// ----------------------------------------------------------------------------
package tte_pkg;
	localparam int SLOTS     = 16;
	localparam int SLOT_W    = 4;
	localparam int TIME_W    = 48;
	localparam int PERIOD_W  = 32;
	localparam int CMD_W     = 3;
	localparam int ST_W      = 3;
	localparam int IN_DATA_W = 96;
	localparam int OUT_DATA_W = 56;

	localparam logic [CMD_W-1:0] CMD_ADD     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_CANCEL  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REFRESH = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RESET   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_NEXT    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_EXPIRE  = 3'd5;

	localparam logic [ST_W-1:0] ST_OK        = 3'd0;
	localparam logic [ST_W-1:0] ST_INACTIVE  = 3'd1;
	localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
	localparam logic [ST_W-1:0] ST_UNCHANGED = 3'd3;
	localparam logic [ST_W-1:0] ST_NO_TIMER  = 3'd4;

	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic [SLOT_W-1:0]   slot;
		logic                recurring;
		logic [PERIOD_W-1:0] period;
		logic                base_now;
		logic [TIME_W-1:0]   now;
	} cmd_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [SLOT_W-1:0] slot_out;
		logic [TIME_W-1:0] remaining;
		logic              was_recurring;
		logic              front_notice;
		logic              last;
	} res_t;
endpackage

FILE: rtl/core/tte_ram.sv
// ----------------------------------------------------------------------------
// tte_ram: generic single-port-write, one-read RAM
// Registered read data.
// ----------------------------------------------------------------------------
module tte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/core/tte_front.sv
// ----------------------------------------------------------------------------
// tte_front: command intake
// Registers incoming commands into a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module tte_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tte_pkg::cmd_t     in_cmd,
	output logic              q_valid,
	input  logic              q_pop,
	output tte_pkg::cmd_t     q_cmd
);
	tte_pkg::cmd_t ent_q [2];
	logic [1:0] cnt_q;
	logic       rd_q, wr_q;
	logic       push;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_cmd    = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (q_pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= in_cmd;
	end

	property p_no_pop_empty;
		@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid;
	endproperty
	a_no_pop_empty: assert property (p_no_pop_empty) else $error("pop from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count overflow");
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !q_pop) |=> cnt_q == 2'd2) else $error("queue lost entry");
endmodule

FILE: rtl/core/tte_back.sv
// ----------------------------------------------------------------------------
// tte_back: timer table executor
// Scans the slot table one slot per cycle, updates it, emits results.
// ----------------------------------------------------------------------------
module tte_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  tte_pkg::cmd_t        q_cmd,
	output logic                 res_valid,
	input  logic                 res_ready,
	output tte_pkg::res_t        res
);
	localparam int SW = tte_pkg::SLOT_W;
	localparam int TW = tte_pkg::TIME_W;
	localparam int PW = tte_pkg::PERIOD_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_RD    = 3'd2;
	localparam logic [2:0] S_EXEC  = 3'd3;

	logic [2:0] state_q;
	tte_pkg::cmd_t cmd_q;
	logic [tte_pkg::SLOTS-1:0] valid_q, rec_q, due_q;
	logic front_pending_q;
	logic [TW-1:0] exp_q [tte_pkg::SLOTS];
	logic [SW:0]   idx_q;
	logic          found_q;
	logic [SW-1:0] best_q;
	logic [TW-1:0] best_exp_q;
	logic          front_ok_q;
	logic          pass2_q;
	logic [SW-1:0] tgt_q;
	logic [TW-1:0] new_exp_q;

	// period RAM
	logic          p_we;
	logic [SW-1:0] p_waddr, p_raddr;
	logic [PW-1:0] p_wdata, p_rdata;

	tte_ram #(.WIDTH(PW), .DEPTH(tte_pkg::SLOTS)) u_period (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata)
	);

	logic [SW-1:0] i;
	logic          cand;
	logic          earlier;
	logic [TW-1:0] per_ext;
	logic [TW-1:0] base;
	logic [TW-1:0] nexp;
	logic          out_busy;
	logic [tte_pkg::SLOTS-1:0] due_rest;

	assign i = idx_q[SW-1:0];
	assign out_busy = res_valid && !res_ready;
	assign per_ext = {{(TW-PW){1'b0}}, p_rdata};
	// expire re-arms the slot it found, everything else works on the target slot
	assign p_raddr = (cmd_q.command == tte_pkg::CMD_EXPIRE) ? best_q : tgt_q;

	always_comb begin
		cand = 1'b0;
		case (cmd_q.command)
			tte_pkg::CMD_EXPIRE: cand = due_q[i];
			default:             cand = valid_q[i];
		endcase
		earlier = !found_q || (exp_q[i] < best_exp_q);
		base = cmd_q.base_now ? cmd_q.now : exp_q[tgt_q] - per_ext;
		case (cmd_q.command)
			tte_pkg::CMD_RESET: nexp = base + {{(TW-PW){1'b0}}, cmd_q.period};
			default:            nexp = cmd_q.now + per_ext;
		endcase
		due_rest = due_q;
		due_rest[best_q] = 1'b0;
	end

	// front check: the target slot is front if no other valid slot expires earlier, or at the same time with a lower index
	logic other_first;
	always_comb begin
		other_first = 1'b0;
		if (i != tgt_q && valid_q[i]) begin
			if (exp_q[i] < new_exp_q)
				other_first = 1'b1;
			else if (exp_q[i] == new_exp_q && i < tgt_q)
				other_first = 1'b1;
		end
	end

	always_comb begin
		p_we    = 1'b0;
		p_waddr = tgt_q;
		p_wdata = cmd_q.period;
		if (state_q == S_EXEC && !out_busy && cmd_q.command == tte_pkg::CMD_RESET
		    && valid_q[tgt_q])
			p_we = 1'b1;
		if (state_q == S_SCAN && cmd_q.command == tte_pkg::CMD_ADD && pass2_q
		    && idx_q == '0) begin
			p_we = 1'b1;
		end
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;

	// due flags: valid slots whose expiry is at or before the command's now
	logic [tte_pkg::SLOTS-1:0] due_next;
	always_comb begin
		for (int k = 0; k < tte_pkg::SLOTS; k++)
			due_next[k] = valid_q[k] && (exp_q[k] <= q_cmd.now);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			valid_q         <= '0;
			rec_q           <= '0;
			due_q           <= '0;
			front_pending_q <= 1'b1;
			res_valid       <= 1'b0;
			res             <= '0;
			cmd_q           <= '0;
			exp_q           <= '{default: '0};
			idx_q           <= '0;
			found_q         <= 1'b0;
			best_q          <= '0;
			best_exp_q      <= '0;
			front_ok_q      <= 1'b0;
			pass2_q         <= 1'b0;
			tgt_q           <= '0;
			new_exp_q       <= '0;
		end else begin
			if (res_valid && res_ready)
				res_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (q_valid) begin
					state_q <= S_SCAN;
					cmd_q   <= q_cmd;
					tgt_q   <= (q_cmd.command == tte_pkg::CMD_ADD) ? '0 : q_cmd.slot;
					found_q <= 1'b0;
					idx_q   <= '0;
					pass2_q <= 1'b0;
					due_q   <= due_next;
				end
				S_SCAN: begin
					if (pass2_q) begin
						// front check over all slots against new_exp_q
						if (idx_q[SW] == 1'b0 && other_first)
							front_ok_q <= 1'b0;
						if (idx_q[SW] == 1'b1) begin
							if (!out_busy) begin
								res_valid      <= 1'b1;
								res.status     <= tte_pkg::ST_OK;
								res.slot_out   <= tgt_q;
								res.remaining  <= '0;
								res.was_recurring <= 1'b0;
								res.last       <= 1'b1;
								res.front_notice <= front_ok_q && front_pending_q;
								if (front_ok_q)
									front_pending_q <= 1'b0;
								if (cmd_q.command == tte_pkg::CMD_ADD) begin
									valid_q[tgt_q] <= 1'b1;
									rec_q[tgt_q]   <= cmd_q.recurring;
								end
								state_q <= S_IDLE;
							end
						end else
							idx_q <= idx_q + (SW+1)'(1);
					end else if (idx_q[SW] == 1'b0) begin
						if (cand && earlier) begin
							found_q    <= 1'b1;
							best_q     <= i;
							best_exp_q <= exp_q[i];
						end
						// add takes the lowest free slot
						if (cmd_q.command == tte_pkg::CMD_ADD && !valid_q[i]
						    && (i < tgt_q || valid_q[tgt_q]))
							tgt_q <= i;
						idx_q <= idx_q + (SW+1)'(1);
					end else
						state_q <= S_RD;
				end
				S_RD: state_q <= S_EXEC;
				S_EXEC: if (!out_busy) begin
					res_valid         <= 1'b1;
					res.status        <= tte_pkg::ST_OK;
					res.slot_out      <= '0;
					res.remaining     <= '0;
					res.was_recurring <= 1'b0;
					res.front_notice  <= 1'b0;
					res.last          <= 1'b1;
					state_q           <= S_IDLE;
					unique case (cmd_q.command)
						tte_pkg::CMD_ADD: begin
							if (&valid_q) begin
								res.status <= tte_pkg::ST_FULL;
							end else begin
								new_exp_q  <= cmd_q.now + {{(TW-PW){1'b0}}, cmd_q.period};
								exp_q[tgt_q] <= cmd_q.now + {{(TW-PW){1'b0}}, cmd_q.period};
								res_valid  <= 1'b0;
								pass2_q    <= 1'b1;
								front_ok_q <= 1'b1;
								idx_q      <= '0;
								state_q    <= S_SCAN;
							end
						end
						tte_pkg::CMD_CANCEL, tte_pkg::CMD_REFRESH, tte_pkg::CMD_RESET: begin
							res.slot_out <= tgt_q;
							if (!valid_q[tgt_q])
								res.status <= tte_pkg::ST_INACTIVE;
							else if (cmd_q.command == tte_pkg::CMD_CANCEL)
								valid_q[tgt_q] <= 1'b0;
							else if (cmd_q.command == tte_pkg::CMD_RESET
							         && nexp == exp_q[tgt_q]) begin
								res.status <= tte_pkg::ST_UNCHANGED;
							end else begin
								new_exp_q    <= nexp;
								exp_q[tgt_q] <= nexp;
								res_valid    <= 1'b0;
								pass2_q      <= 1'b1;
								front_ok_q   <= 1'b1;
								idx_q        <= '0;
								state_q      <= S_SCAN;
							end
						end
						tte_pkg::CMD_NEXT: begin
							if (!found_q) begin
								res.status    <= tte_pkg::ST_NO_TIMER;
								res.remaining <= '1;
							end else begin
								front_pending_q <= 1'b1;
								res.remaining <= (cmd_q.now >= best_exp_q) ? '0
									: best_exp_q - cmd_q.now;
							end
						end
						tte_pkg::CMD_EXPIRE: begin
							if (!found_q) begin
								res.status <= tte_pkg::ST_NO_TIMER;
							end else begin
								front_pending_q   <= 1'b1;
								due_q[best_q]     <= 1'b0;
								res.slot_out      <= best_q;
								res.was_recurring <= rec_q[best_q];
								if (rec_q[best_q])
									exp_q[best_q] <= cmd_q.now + per_ext;
								else
									valid_q[best_q] <= 1'b0;
								// more due slots: rescan for the next one
								if (due_rest != '0) begin
									res.last <= 1'b0;
									found_q  <= 1'b0;
									idx_q    <= '0;
									state_q  <= S_SCAN;
								end
							end
						end
						default: ;
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == S_IDLE) else $error("pop outside idle");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> res_valid) else $error("result dropped");
	a_pend_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.front_notice && $rose(res_valid)) |-> !front_pending_q)
		else $error("front pending not cleared");
endmodule

FILE: rtl/core/timer_table_engine.sv
// ----------------------------------------------------------------------------
// timer_table_engine: sixteen-slot software timer table
// Top level joining the command intake queue and the table executor.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_axis group, one transfer per command. Results leave
//   on the m_axis group; every command gives one result except expire, which
//   gives one per due slot in expiry order (one no-timer result if none is
//   due), tlast on the final one. A result comes after a scan of the slot
//   table, one slot a cycle, a period RAM read and an execute step; add,
//   refresh and reset add a front-check scan when they set a new expiry.
//   Each further expire result follows a new scan of the slot table.
//   The executor takes no new command until it is done with the last one;
//   the queue holds commands meanwhile.
//   A two-entry queue lets up to two commands wait while the executor works.
//   Reset clears all slots and arms the front notice; no clearing pass.
//   When the receiver stalls, the held result stays and the executor waits before giving its next result.
// ----------------------------------------------------------------------------
module timer_table_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// command[2:0], slot[6:3], recurring[7], period[39:8], base_now[40], now[88:41]
	input  logic [tte_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[2:0], slot_out[6:3], remaining[54:7], was_recurring[55]
	output logic [tte_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// front_notice
	output logic        m_axis_tuser,
	output logic        m_axis_tlast
);
	tte_pkg::cmd_t in_cmd, q_cmd;
	tte_pkg::res_t res;
	logic q_valid, q_pop;

	assign in_cmd.command   = s_axis_tdata[2:0];
	assign in_cmd.slot      = s_axis_tdata[6:3];
	assign in_cmd.recurring = s_axis_tdata[7];
	assign in_cmd.period    = s_axis_tdata[39:8];
	assign in_cmd.base_now  = s_axis_tdata[40];
	assign in_cmd.now       = s_axis_tdata[88:41];

	tte_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_cmd(in_cmd), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
	);

	tte_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
	);

	assign m_axis_tdata = {res.was_recurring, res.remaining, res.slot_out, res.status};
	assign m_axis_tuser = res.front_notice;
	assign m_axis_tlast = res.last;
endmodule
